// ----- hdl/radial_spotlight_luminance_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radial spotlight block
// Concurrent checks used by the assertions of the top-level module.
// ----------------------------------------------------------------------------
`ifndef RADIAL_SPOTLIGHT_LUMINANCE_DEFINES_SVH
`define RADIAL_SPOTLIGHT_LUMINANCE_DEFINES_SVH

// Same-cycle implication, masked while reset is applied.
`define RSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spotlight check failed");

// Next-cycle implication, masked while reset is applied.
`define RSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spotlight check failed");

// Next-cycle implication that also holds across reset.
`define RSL_ASSERT_ALWAYS_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("spotlight check failed");

`endif

// ----- hdl/rsl_pkg.sv -----
// ----------------------------------------------------------------------------
// Radial spotlight package
// Shared constants and types for the spotlight pipeline.
// ----------------------------------------------------------------------------
package rsl_pkg;

    // Default widths of the pixel fields.
    localparam int COORD_BITS_DEF = 12;
    localparam int LUMA_BITS_DEF  = 16;

    // Configuration port.
    localparam int CENTER_BITS  = 14;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 1'b1;

    // Spotlight geometry: inside the radius the squared distance fits D2_BITS.
    localparam int RADIUS    = 160;
    localparam int RADIUS_SQ = RADIUS * RADIUS;
    localparam int D2_BITS   = 15;

    // Square root of d2 * 2^16: a 32-bit radicand, 16 root bits, one per cell.
    localparam int ROOT_BITS = 16;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 1;

    // floor(root * 32 / 25) as floor(root * RECIP / 2^RECIP_SHIFT).
    localparam int RECIP_BITS  = 22;
    localparam int RECIP_SHIFT = 21;
    localparam logic [RECIP_BITS-1:0] RECIP = 22'd2684355;

    // Attenuation factor in Q16.
    localparam int FACTOR_BITS = 17;
    localparam logic [FACTOR_BITS-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FACTOR_BITS-1:0] FAR_FACTOR = 17'd13107;
    localparam int FRAC_BITS = 16;

    // Control that travels alongside every item in the pipeline.
    typedef struct packed {
        logic valid;
        logic far;
    } t_ctl;

endpackage

// ----- hdl/rsl_dist.sv -----
// ----------------------------------------------------------------------------
// Spotlight distance front end
// Forms the squared distance to the centre over three registered stages.
// ----------------------------------------------------------------------------
module rsl_dist
    import rsl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUMA_BITS  = LUMA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [COORD_BITS-1:0]         i_pixel_x,
    input  logic [COORD_BITS-1:0]         i_pixel_y,
    input  logic [LUMA_BITS-1:0]          i_luma_in,
    input  logic signed [CENTER_BITS-1:0] i_center_x,
    input  logic signed [CENTER_BITS-1:0] i_center_y,
    output t_ctl                          o_ctl,
    output logic [D2_BITS-1:0]            o_d2,
    output logic [LUMA_BITS-1:0]          o_luma
);

    localparam int DX_W = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 2;
    localparam int SQ_W = 2 * DX_W;
    localparam int D2_W = SQ_W + 1;

    logic                    r_a_valid, r_b_valid;
    t_ctl                    r_c_ctl;
    logic signed [DX_W-1:0]  r_dx, r_dy;
    logic signed [SQ_W-1:0]  r_sq_x, r_sq_y;
    logic [LUMA_BITS-1:0]    r_a_luma, r_b_luma, r_c_luma;
    logic [D2_BITS-1:0]      r_c_d2;
    logic signed [DX_W-1:0]  n_dx, n_dy;
    logic [D2_W-1:0]         n_d2;

    // Coordinate differences, with the centre sign-extended.
    always_comb begin
        n_dx = $signed({{(DX_W-COORD_BITS){1'b0}}, i_pixel_x}) - DX_W'(i_center_x);
        n_dy = $signed({{(DX_W-COORD_BITS){1'b0}}, i_pixel_y}) - DX_W'(i_center_y);
    end

    // Sum of squares; both squares are non-negative.
    assign n_d2 = D2_W'($unsigned(r_sq_x)) + D2_W'($unsigned(r_sq_y));

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_ctl   <= '0;
        end else if (i_adv) begin
            r_a_valid     <= i_valid;
            r_b_valid     <= r_a_valid;
            r_c_ctl.valid <= r_b_valid;
            r_c_ctl.far   <= (n_d2 > D2_W'(RADIUS_SQ));
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_a_luma <= i_luma_in;
            r_sq_x   <= r_dx * r_dx;
            r_sq_y   <= r_dy * r_dy;
            r_b_luma <= r_a_luma;
            r_c_d2   <= n_d2[D2_BITS-1:0];
            r_c_luma <= r_b_luma;
        end
    end

    assign o_ctl  = r_c_ctl;
    assign o_d2   = r_c_d2;
    assign o_luma = r_c_luma;

endmodule

// ----- hdl/rsl_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// Settles one root bit of d2 * 2^16 and hands the item to the next cell.
// ----------------------------------------------------------------------------
module rsl_sqrt_cell
    import rsl_pkg::*;
#(
    parameter int LUMA_BITS = LUMA_BITS_DEF,
    parameter int STEP      = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  t_ctl                 i_ctl,
    input  logic [D2_BITS-1:0]   i_d2,
    input  logic [REM_BITS-1:0]  i_rem,
    input  logic [ROOT_BITS-1:0] i_root,
    input  logic [LUMA_BITS-1:0] i_luma,
    output t_ctl                 o_ctl,
    output logic [D2_BITS-1:0]   o_d2,
    output logic [REM_BITS-1:0]  o_rem,
    output logic [ROOT_BITS-1:0] o_root,
    output logic [LUMA_BITS-1:0] o_luma
);

    localparam int PAIR_HI = RAD_BITS - 1 - 2 * STEP;

    t_ctl                 r_ctl;
    logic [D2_BITS-1:0]   r_d2;
    logic [REM_BITS-1:0]  r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [LUMA_BITS-1:0] r_luma;

    logic [RAD_BITS-1:0]  w_radicand;
    logic [REM_BITS+1:0]  w_rem_sh;
    logic [REM_BITS+1:0]  w_trial;
    logic                 w_ge;
    logic [REM_BITS+1:0]  w_diff;
    logic [REM_BITS-1:0]  n_rem;
    logic [ROOT_BITS-1:0] n_root;

    // Bring down the next two radicand bits and try a one in this root bit.
    always_comb begin
        w_radicand = {{(RAD_BITS-D2_BITS-FRAC_BITS){1'b0}}, i_d2, {FRAC_BITS{1'b0}}};
        w_rem_sh   = {i_rem, w_radicand[PAIR_HI -: 2]};
        w_trial    = {1'b0, i_root, 2'b01};
        w_ge       = (w_rem_sh >= w_trial);
        w_diff     = w_rem_sh - w_trial;
        n_rem      = w_ge ? w_diff[REM_BITS-1:0] : w_rem_sh[REM_BITS-1:0];
        n_root     = {i_root[ROOT_BITS-2:0], w_ge};
    end

    // Control moves with the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    // Partial root, remainder and passenger fields.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d2   <= i_d2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_luma <= i_luma;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_d2   = r_d2;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_luma = r_luma;

endmodule

// ----- hdl/rsl_scale.sv -----
// ----------------------------------------------------------------------------
// Spotlight scaling back end
// Turns the Q8 distance into a Q16 factor and scales the luminance.
// ----------------------------------------------------------------------------
module rsl_scale
    import rsl_pkg::*;
#(
    parameter int LUMA_BITS = LUMA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  t_ctl                 i_ctl,
    input  logic [ROOT_BITS-1:0] i_root,
    input  logic [LUMA_BITS-1:0] i_luma,
    output logic                 o_valid,
    output logic [LUMA_BITS-1:0] o_luma_out
);

    localparam int RPROD_W = ROOT_BITS + RECIP_BITS;
    localparam int LPROD_W = LUMA_BITS + FACTOR_BITS;

    t_ctl                   r_d_ctl;
    logic                   r_e_valid, r_out_valid;
    logic [RPROD_W-1:0]     r_rprod;
    logic [LUMA_BITS-1:0]   r_d_luma, r_e_luma, r_luma_out;
    logic [FACTOR_BITS-1:0] r_factor;
    logic [FACTOR_BITS-1:0] n_factor;
    logic [LPROD_W-1:0]     w_lprod;

    // One minus 0.005 times the distance, or the fixed far factor.
    always_comb begin
        if (r_d_ctl.far) begin
            n_factor = FAR_FACTOR;
        end else begin
            n_factor = ONE_Q16 - r_rprod[RECIP_SHIFT +: FACTOR_BITS];
        end
    end

    assign w_lprod = LPROD_W'(r_e_luma) * LPROD_W'(r_factor);

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl     <= '0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_ctl     <= i_ctl;
            r_e_valid   <= r_d_ctl.valid;
            r_out_valid <= r_e_valid;
        end
    end

    // Reciprocal multiply, factor, then the luminance product.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rprod    <= RPROD_W'(i_root) * RPROD_W'(RECIP);
            r_d_luma   <= i_luma;
            r_factor   <= n_factor;
            r_e_luma   <= r_d_luma;
            r_luma_out <= w_lprod[FRAC_BITS +: LUMA_BITS];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_luma_out = r_luma_out;

endmodule

// ----- hdl/radial_spotlight_luminance.sv -----
// ----------------------------------------------------------------------------
// Radial spotlight luminance
// Darkens each pixel with its distance from a configurable spotlight centre.
// ----------------------------------------------------------------------------
// Usage:
// Input items (pixel_x, pixel_y, luma_in) arrive on a valid/stall channel and
// each gives exactly one luma_out item on the output valid/stall channel, in
// order. The pipeline takes one item per cycle while not stalled, through
// three distance stages, sixteen square root cells (one root bit per cell)
// and three scaling stages, the last of which is the output register.
// When the receiver stalls while a result is shown, the whole pipeline holds
// and o_stall rises in the same cycle; no item is dropped. Items in flight
// continue as soon as the stall drops, one per cycle again.
// The centre registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data, and should change only while no item is in flight.
// Reset clears all valid bits and sets both centre coordinates to zero.
// ----------------------------------------------------------------------------
`include "radial_spotlight_luminance_defines.svh"

module radial_spotlight_luminance
    import rsl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUMA_BITS  = LUMA_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CENTER_BITS-1:0]  i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [COORD_BITS-1:0]   i_pixel_x,
    input  logic [COORD_BITS-1:0]   i_pixel_y,
    input  logic [LUMA_BITS-1:0]    i_luma_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [LUMA_BITS-1:0]    o_luma_out
);

    logic signed [CENTER_BITS-1:0] r_center_x, r_center_y;
    logic                          w_adv;

    t_ctl                 w_ctl  [0:ROOT_BITS];
    logic [D2_BITS-1:0]   w_d2   [0:ROOT_BITS];
    logic [REM_BITS-1:0]  w_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] w_root [0:ROOT_BITS];
    logic [LUMA_BITS-1:0] w_luma [0:ROOT_BITS];

    // The pipeline moves unless a shown result is being held back.
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Centre registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CENTER_X) begin
                r_center_x <= $signed(i_cfg_data);
            end
            if (i_cfg_idx == CFG_CENTER_Y) begin
                r_center_y <= $signed(i_cfg_data);
            end
        end
    end

    // Squared distance.
    rsl_dist #(
        .COORD_BITS (COORD_BITS),
        .LUMA_BITS  (LUMA_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (i_valid),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_luma_in  (i_luma_in),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_ctl      (w_ctl[0]),
        .o_d2       (w_d2[0]),
        .o_luma     (w_luma[0])
    );

    // The root starts empty with a zero remainder.
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // Square root chain, one cell per root bit.
    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        rsl_sqrt_cell #(
            .LUMA_BITS (LUMA_BITS),
            .STEP      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_d2    (w_d2[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_luma  (w_luma[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_d2    (w_d2[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_luma  (w_luma[g+1])
        );
    end

    // Factor and luminance scaling.
    rsl_scale #(
        .LUMA_BITS (LUMA_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_ctl      (w_ctl[ROOT_BITS]),
        .i_root     (w_root[ROOT_BITS]),
        .i_luma     (w_luma[ROOT_BITS]),
        .o_valid    (o_valid),
        .o_luma_out (o_luma_out)
    );

    // Checks.
    `RSL_ASSERT_ALWAYS_NEXT(a_reset_empties, !i_rst_n, !o_valid)
    `RSL_ASSERT_NOW(a_stall_needs_result, o_stall, o_valid)
    `RSL_ASSERT_NEXT(a_result_held, o_valid && i_stall, o_valid && $stable(o_luma_out))

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radial spotlight luminance testbench
// Sends pixel items through the valid/stall input channel and checks every
// luma_out item against an in-bench model of the spotlight attenuation.
// A short directed part covers far-off centres, the exact radius, far
// pixels and luminance extremes. Random phases follow, each with its own
// centre; sender gaps and receiver stalls are random outside burst phases.
// ----------------------------------------------------------------------------
module tb;
    import rsl_pkg::*;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int LUMA_BITS    = LUMA_BITS_DEF;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int SPOT_R       = 160;
    localparam int FAR_Q16      = 13107;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 90;

    typedef struct {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [LUMA_BITS-1:0]  luma;
        int unsigned           gap;
        bit                    drain;
    } t_pixel_item;

    // DUT ports
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx  = CFG_CENTER_X;
    logic [CENTER_BITS-1:0]  i_cfg_data = '0;
    logic                    i_valid    = 1'b0;
    logic                    o_stall;
    logic [COORD_BITS-1:0]   i_pixel_x  = '0;
    logic [COORD_BITS-1:0]   i_pixel_y  = '0;
    logic [LUMA_BITS-1:0]    i_luma_in  = '0;
    logic                    o_valid;
    logic                    i_stall    = 1'b0;
    logic [LUMA_BITS-1:0]    o_luma_out;

    // Bench state
    t_pixel_item             pixel_q[$];
    logic [LUMA_BITS-1:0]    luma_expect_q[$];
    logic signed [CENTER_BITS-1:0] ctr_x = '0;
    logic signed [CENTER_BITS-1:0] ctr_y = '0;
    bit                      in_fire    = 1'b0;
    bit                      out_fire   = 1'b0;
    bit                      send_burst = 1'b0;
    bit                      recv_burst = 1'b0;
    int unsigned             gap_cnt    = 0;
    int unsigned             stall_left = 0;
    int unsigned             n_err      = 0;
    int unsigned             cycles     = 0;

    radial_spotlight_luminance #(
        .COORD_BITS(COORD_BITS),
        .LUMA_BITS (LUMA_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_luma_in  (i_luma_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_luma_out (o_luma_out)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Attenuated luminance for one pixel under the current centre.
    function automatic logic [LUMA_BITS-1:0] spot_luma(input logic [COORD_BITS-1:0] px,
                                                       input logic [COORD_BITS-1:0] py,
                                                       input logic [LUMA_BITS-1:0] luma);
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned factor;
        longint unsigned scaled;
        dx = longint'(px) - longint'(ctr_x);
        dy = longint'(py) - longint'(ctr_y);
        d2 = longint'(dx * dx + dy * dy);
        if (d2 > SPOT_R * SPOT_R) begin
            factor = FAR_Q16;
        end else begin
            // Bitwise integer square root of d2 in Q16, giving distance in Q8.
            rad  = d2 << 16;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rad)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rad >= root + bitv) begin
                    rad  = rad - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            factor = 65536 - (root * 128) / 100;
        end
        scaled = (longint'(luma) * factor) >> 16;
        return scaled[LUMA_BITS-1:0];
    endfunction

    // Queue one pixel item; the gap before it is drawn here.
    task automatic push_pixel(input int px, input int py, input int luma, input bit drain = 0);
        t_pixel_item it;
        it.px    = px[COORD_BITS-1:0];
        it.py    = py[COORD_BITS-1:0];
        it.luma  = luma[LUMA_BITS-1:0];
        it.gap   = send_burst ? 0 : $urandom_range(0, 3);
        it.drain = drain;
        pixel_q.push_back(it);
    endtask

    // Wait until every item is sent and every result has come, then let the
    // pipeline run empty.
    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_valid || luma_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic signed [CENTER_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CENTER_X)
            ctr_x = val;
        else
            ctr_y = val;
    endtask

    task automatic set_center(input int cx, input int cy);
        wait_idle();
        cfg_write(CFG_CENTER_X, cx[CENTER_BITS-1:0]);
        cfg_write(CFG_CENTER_Y, cy[CENTER_BITS-1:0]);
    endtask

    // Input driver: holds a stalled item, otherwise idles out the gap of the
    // next item and presents it.
    always @(negedge i_clk) begin
        t_pixel_item it;
        if (!i_valid || in_fire) begin
            if (pixel_q.size() == 0 || (pixel_q[0].drain && luma_expect_q.size() != 0)) begin
                i_valid <= 1'b0;
            end else if (gap_cnt < pixel_q[0].gap) begin
                i_valid <= 1'b0;
                gap_cnt++;
            end else begin
                it = pixel_q.pop_front();
                gap_cnt = 0;
                i_pixel_x <= it.px;
                i_pixel_y <= it.py;
                i_luma_in <= it.luma;
                i_valid   <= 1'b1;
            end
        end
    end

    // Receiver: a fresh stall count after every taken result, counted down
    // while a result is shown.
    always @(negedge i_clk) begin
        if (out_fire)
            stall_left = recv_burst ? 0 : $urandom_range(0, 3);
        else if (o_valid && stall_left != 0)
            stall_left--;
        i_stall <= (stall_left != 0);
    end

    // Monitor and scoreboard.
    always @(posedge i_clk) begin
        logic [LUMA_BITS-1:0] want;
        in_fire  = i_rst_n && i_valid && !o_stall;
        out_fire = i_rst_n && o_valid && !i_stall;
        if (out_fire) begin
            if (luma_expect_q.size() == 0) begin
                $error("luma_out: no item waiting, actual %0d", o_luma_out);
                n_err++;
            end else begin
                want = luma_expect_q.pop_front();
                if (o_luma_out !== want) begin
                    $error("luma_out: expected %0d, actual %0d", want, o_luma_out);
                    n_err++;
                end
            end
        end
        if (in_fire)
            luma_expect_q.push_back(spot_luma(i_pixel_x, i_pixel_y, i_luma_in));
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        int cx;
        int cy;
        int tx;
        int ty;
        int lum;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Centre at its reset value: zero distance, exact radius, just past it.
        push_pixel(0, 0, 65535);
        push_pixel(0, 0, 0);
        push_pixel(160, 0, 65535);
        push_pixel(96, 128, 40000);
        push_pixel(161, 0, 65535);
        push_pixel(0, 160, 1);
        push_pixel(113, 113, 65535);
        push_pixel(1, 0, 65535);
        push_pixel(COORD_MAX, COORD_MAX, 65535);

        // Centre left of the image: the radius reaches in from outside.
        set_center(-100, 0);
        push_pixel(60, 0, 65535);
        push_pixel(61, 0, 65535);

        // Centres far outside the image, up to the largest positive value.
        set_center(-4096, 8191);
        push_pixel(0, COORD_MAX, 65535);
        push_pixel(COORD_MAX, 0, 65535);
        set_center(8191, -4096);
        push_pixel(COORD_MAX, 0, 65535);
        push_pixel(0, COORD_MAX, 32768);

        // Centre near the far corner of the image.
        set_center(4000, 4000);
        push_pixel(COORD_MAX, COORD_MAX, 65535);
        push_pixel(4000, 4000, 65535);
        push_pixel(3840, 4000, 65535);
        push_pixel(4000, 3999, 12345);

        // Random phases, mostly with the centre near the image.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            send_burst = (p % 3 == 1);
            recv_burst = (p % 3 == 0);
            if (p == 0) begin
                cx = -4096;
                cy = -4096;
            end else if (p == 1) begin
                cx = 8191;
                cy = 8191;
            end else begin
                cx = int'($urandom_range(0, 4400)) - 200;
                cy = int'($urandom_range(0, 4400)) - 200;
            end
            set_center(cx, cy);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        tx = $urandom_range(0, COORD_MAX);
                        ty = $urandom_range(0, COORD_MAX);
                    end
                    2: begin
                        // A point on the radius circle.
                        case ($urandom_range(0, 3))
                            0: begin tx = 160; ty = 0;   end
                            1: begin tx = 96;  ty = 128; end
                            2: begin tx = 128; ty = 96;  end
                            default: begin tx = 0; ty = 160; end
                        endcase
                        tx = $urandom_range(0, 1) ? cx + tx : cx - tx;
                        ty = $urandom_range(0, 1) ? cy + ty : cy - ty;
                    end
                    default: begin
                        tx = cx + int'($urandom_range(0, 340)) - 170;
                        ty = cy + int'($urandom_range(0, 340)) - 170;
                    end
                endcase
                if (tx < 0) tx = 0;
                if (tx > COORD_MAX) tx = COORD_MAX;
                if (ty < 0) ty = 0;
                if (ty > COORD_MAX) ty = COORD_MAX;
                case ($urandom_range(0, 7))
                    0: lum = 0;
                    1: lum = 65535;
                    default: lum = $urandom_range(0, 65535);
                endcase
                // Halfway through some phases the sender waits for the pipeline to empty.
                push_pixel(tx, ty, lum, (k == PHASE_ITEMS / 2) && (p % 2 == 0));
            end
        end

        wait_idle();
        if (n_err == 0 && luma_expect_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- radial_spotlight_luminance.f -----
+incdir+hdl
hdl/rsl_pkg.sv
hdl/rsl_dist.sv
hdl/rsl_sqrt_cell.sv
hdl/rsl_scale.sv
hdl/radial_spotlight_luminance.sv
dv/tb.sv
